// ===== hdl/scfe_pkg.sv =====
// ----------------------------------------------------------------------------
// scfe_pkg: servo command frame encoder shared types and constants
// Request and frame byte payloads, action codes, frame bytes and sizes.
// ----------------------------------------------------------------------------
package scfe_pkg;

	// action codes
	localparam logic [1:0] ACT_POS_WRITE = 2'd0;
	localparam logic [1:0] ACT_SET_ID    = 2'd1;
	localparam logic [1:0] ACT_POS_READ  = 2'd2;

	// configuration register indexes
	localparam logic REG_POS_MIN = 1'b0;
	localparam logic REG_POS_MAX = 1'b1;

	localparam logic [15:0] POS_MIN_RESET = 16'd96;
	localparam logic [15:0] POS_MAX_RESET = 16'd4000;

	// frame bytes
	localparam logic [7:0] SYNC_BYTE      = 8'hFF;
	localparam logic [7:0] BROADCAST_ID   = 8'hFE;
	localparam logic [7:0] LEN_POS_WRITE  = 8'h07;
	localparam logic [7:0] LEN_SHORT      = 8'h04;
	localparam logic [7:0] INSTR_WRITE    = 8'h03;
	localparam logic [7:0] INSTR_READ     = 8'h02;
	localparam logic [7:0] ADDR_GOAL_POS  = 8'h2A;
	localparam logic [7:0] ADDR_ID        = 8'h05;
	localparam logic [7:0] ADDR_PRES_POS  = 8'h38;
	localparam logic [7:0] READ_COUNT     = 8'h02;
	localparam logic [7:0] ID_LIMIT       = 8'd250;

	// sizes
	localparam int BODY_MAX  = 8;
	localparam int FRAME_MAX = BODY_MAX + 3;
	localparam int CNT_W     = $clog2(FRAME_MAX + 1);

	localparam logic [CNT_W-1:0] BODY_POS_WRITE = CNT_W'(8);
	localparam logic [CNT_W-1:0] BODY_SHORT     = CNT_W'(5);

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  servo_id;
		logic [15:0] position;
		logic [15:0] move_time;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} frm_t;

endpackage

// ===== hdl/servo_command_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// servo_command_frame_encoder
// Turns one servo command request into a bus frame, sent one byte per
// transfer: FF FF, id, length, instruction, parameters, inverted checksum.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | req_t: action, id, pos, time
//  frm     | out       | frm_valid / frm_ready | frm_t: tx_byte, last_byte
//  cfg     | in        | cfg_we                | cfg_index, cfg_data (16 bit)
//
// A request is captured in the input register, its whole frame (bytes and
// checksum) is built combinationally and loaded into the frame shift register,
// then one byte leaves per cycle while frm_ready is high: 11 bytes for a
// position write, 8 for the other actions; a rejected request yields no
// transfer. The frame register length sets the rate: the next frame loads in
// the cycle its predecessor's last byte is taken, so frames go out back to
// back. Reset clears the valid flags and the byte count and loads the
// limits with 96 and 4000.
// A stall on frm holds the frame register and, through it, the input register.
// ----------------------------------------------------------------------------
module servo_command_frame_encoder
	import scfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        frm_valid,
	input  logic        frm_ready,
	output frm_t        frm
);

	// configuration limits
	logic [15:0] pos_min_q;
	logic [15:0] pos_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q <= POS_MIN_RESET;
			pos_max_q <= POS_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_MIN: pos_min_q <= cfg_data;
				REG_POS_MAX: pos_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame register: remaining byte count, bytes shift toward slot 0
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       frame_q [FRAME_MAX];

	logic out_fire;
	logic load;

	assign frm_valid     = (cnt_q != '0);
	assign out_fire      = frm_valid && frm_ready;
	assign frm.tx_byte   = frame_q[0];
	assign frm.last_byte = (cnt_q == CNT_W'(1));

	// input register
	logic valid_s1;
	req_t req_s1;
	logic slot_free;

	// the frame register takes a new frame when empty or on its final transfer
	assign slot_free = (cnt_q == '0) || (cnt_q == CNT_W'(1) && frm_ready);
	assign load      = valid_s1 && slot_free;
	assign req_ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// frame build from the input register
	logic             id_ok;
	logic             pos_ok;
	logic [7:0]       body [BODY_MAX];
	logic [CNT_W-1:0] body_len;
	logic [7:0]       chk_sum;
	logic [7:0]       chk;
	logic [CNT_W-1:0] frame_len;
	logic [7:0]       frame_d [FRAME_MAX];

	assign id_ok  = (req_s1.servo_id != 8'd0) && (req_s1.servo_id <= ID_LIMIT);
	assign pos_ok = (req_s1.position >= pos_min_q) && (req_s1.position <= pos_max_q);

	always_comb begin
		for (int i = 0; i < BODY_MAX; i++) begin
			body[i] = 8'h00;
		end
		body_len = '0;
		unique case (req_s1.action)
			ACT_POS_WRITE: begin
				body[0]  = req_s1.servo_id;
				body[1]  = LEN_POS_WRITE;
				body[2]  = INSTR_WRITE;
				body[3]  = ADDR_GOAL_POS;
				body[4]  = req_s1.position[15:8];
				body[5]  = req_s1.position[7:0];
				body[6]  = req_s1.move_time[15:8];
				body[7]  = req_s1.move_time[7:0];
				body_len = pos_ok ? BODY_POS_WRITE : '0;
			end
			ACT_SET_ID: begin
				body[0]  = BROADCAST_ID;
				body[1]  = LEN_SHORT;
				body[2]  = INSTR_WRITE;
				body[3]  = ADDR_ID;
				body[4]  = req_s1.servo_id;
				body_len = id_ok ? BODY_SHORT : '0;
			end
			ACT_POS_READ: begin
				body[0]  = req_s1.servo_id;
				body[1]  = LEN_SHORT;
				body[2]  = INSTR_READ;
				body[3]  = ADDR_PRES_POS;
				body[4]  = READ_COUNT;
				body_len = id_ok ? BODY_SHORT : '0;
			end
			default: body_len = '0;
		endcase
	end

	// unused body slots are zero, so summing all of them is harmless
	always_comb begin
		chk_sum = 8'h00;
		for (int i = 0; i < BODY_MAX; i++) begin
			chk_sum = chk_sum + body[i];
		end
	end

	assign chk       = ~chk_sum;
	assign frame_len = (body_len == '0) ? '0 : body_len + CNT_W'(3);

	// two sync bytes, the body, then the checksum right after the last body byte
	always_comb begin
		frame_d[0] = SYNC_BYTE;
		frame_d[1] = SYNC_BYTE;
		for (int i = 0; i < BODY_MAX; i++) begin
			if (CNT_W'(i) < body_len) begin
				frame_d[i + 2] = body[i];
			end else if (CNT_W'(i) == body_len) begin
				frame_d[i + 2] = chk;
			end else begin
				frame_d[i + 2] = 8'h00;
			end
		end
		frame_d[FRAME_MAX - 1] = (body_len == BODY_POS_WRITE) ? chk : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= frame_len;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_d;
		end else if (out_fire) begin
			for (int i = 0; i < FRAME_MAX - 1; i++) begin
				frame_q[i] <= frame_q[i + 1];
			end
			frame_q[FRAME_MAX - 1] <= 8'h00;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_MAX))
		else $error("frame byte count beyond frame size");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> req_ready)
		else $error("request stalled with empty frame register");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && frm.last_byte && !load) |=> !frm_valid)
		else $error("bytes continue after last byte without a new frame");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(frm_valid && !frm_ready) |=> ($stable(cnt_q) && $stable(frm.tx_byte)))
		else $error("frame register moved during a stall");
`endif

endmodule
